// ----- design/mbrc_pkg.sv -----
// Shared types and constants for the Modbus RTU response checker.
// No dependencies; imported by the checker top level.
`default_nettype none
package mbrc_pkg;

   localparam int MBRC_MAX_FRAME   = 64;
   localparam int MBRC_MAX_REGS    = 16;
   localparam int MBRC_MIN_FRAME   = 5;
   localparam int MBRC_DATA_OFFSET = 3;
   localparam logic [7:0]  MBRC_EXC_FLAG = 8'h80;
   localparam logic [15:0] MBRC_CRC_INIT = 16'hFFFF;
   localparam logic [15:0] MBRC_CRC_POLY = 16'hA001;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_CRC_ERR   = 3'd2,
      ST_EXCEPTION = 3'd3,
      ST_FUNC_ERR  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CRC,
      S_CHECK,
      S_RD_HI,
      S_RD_LO,
      S_EMIT
   } state_type;

endpackage
`default_nettype wire

// ----- design/mbrc_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies; used for the frame store of the checker.
`default_nettype none
module mbrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- design/modbus_rtu_response_checker.sv -----
// Top level of the Modbus RTU response checker: frame store, bit-serial CRC and checks.
// Depends on mbrc_pkg and on the generic RAM mbrc_ram.
`default_nettype none

// Each request carries one received byte of a response frame. A request is
// taken when start is high and busy is low; busy then stays high while the
// CRC-16/MODBUS absorbs the byte one bit per cycle. The CRC runs two bytes
// behind the newest stored byte, so the final two bytes are the received CRC,
// low byte first. After the byte marked frame_end the block runs the checks
// (length, CRC, exception echo, function code) and then either reports one
// status result or reads the requested register values out of the frame
// store through S_RD_HI, S_RD_LO and S_EMIT, one register at a time, because
// the single RAM port delivers one byte per read. Results appear for exactly
// one cycle with rsp_valid high; the receiver cannot stall them, and none is
// ever held back. The frame store needs no clearing pass: a valid bit per
// entry, cleared by reset, makes an entry read as zero until it is first
// written. Bytes past the store are dropped, and stale bytes of earlier
// frames stay visible to register reads.

module modbus_rtu_response_checker #(
   parameter int MAX_FRAME = mbrc_pkg::MBRC_MAX_FRAME
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_end,
   input  wire logic [6:0]  req_expected_function,
   input  wire logic [4:0]  req_register_count,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_fault_code,
   output logic [3:0]       rsp_register_index,
   output logic [15:0]      rsp_register_value,
   output logic             rsp_last_result
);
   import mbrc_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);
   // Width of a byte position up to the low byte of the last register that can be read.
   localparam int PW = $clog2(MBRC_DATA_OFFSET + 2 * MBRC_MAX_REGS + 1);

   // Control state.
   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [15:0]     crc_ff, crc_in;
   logic [2:0]      bit_ff, bit_in;
   logic            feed_on_ff, feed_on_in;
   logic            end_ff, end_in;
   logic [MAX_FRAME-1:0] valid_ff, valid_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [7:0]      feed_ff, feed_in;
   logic [7:0]      h1_ff, h1_in;       // newest stored byte of the frame
   logic [7:0]      h2_ff, h2_in;       // the byte stored before it
   logic [7:0]      b1_ff, b1_in;       // frame byte 1, the function code
   logic [7:0]      b2_ff, b2_in;       // frame byte 2, the exception code
   logic [CW-1:0]   n_ff, n_in;
   logic [6:0]      func_ff, func_in;
   logic [4:0]      nreg_ff, nreg_in;
   logic [3:0]      idx_ff, idx_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [7:0]      hi_ff, hi_in;
   logic            rd_ok_ff, rd_ok_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [7:0]      rsp_exc_ff, rsp_exc_in;
   logic [3:0]      rsp_idx_ff, rsp_idx_in;
   logic [15:0]     rsp_val_ff, rsp_val_in;
   logic            rsp_last_ff, rsp_last_in;

   // Frame store port.
   logic            ram_we;
   logic [AW-1:0]   ram_addr;
   logic [7:0]      ram_q;

   mbrc_ram #(
      .WIDTH(8),
      .DEPTH(MAX_FRAME)
   ) u_store (
      .clock(clock),
      .we(ram_we),
      .addr(ram_addr),
      .wdata(req_rx_byte),
      .rdata(ram_q)
   );

   always_comb begin
      logic          full;
      logic          fb;
      logic [31:0]   rd_pos;
      logic [7:0]    rd_byte;
      logic [15:0]   rx_crc;

      state_in      = state_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      bit_in        = bit_ff;
      feed_on_in    = feed_on_ff;
      end_in        = end_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      feed_in       = feed_ff;
      h1_in         = h1_ff;
      h2_in         = h2_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      n_in          = n_ff;
      func_in       = func_ff;
      nreg_in       = nreg_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      hi_in         = hi_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_exc_in    = rsp_exc_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;

      full     = (count_ff == CW'(MAX_FRAME));
      fb       = crc_ff[0] ^ feed_ff[0];
      rx_crc   = {h1_ff, h2_ff};
      rd_byte  = rd_ok_ff ? ram_q : 8'h00;
      ram_we   = 1'b0;
      rd_pos   = 32'(pos_ff);
      ram_addr = count_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ram_we = !full;
               if (!full) begin
                  valid_in[count_ff[AW-1:0]] = 1'b1;
                  // The byte two places back in this frame enters the CRC.
                  feed_on_in = (count_ff >= CW'(2));
                  feed_in    = h2_ff;
                  h2_in      = h1_ff;
                  h1_in      = req_rx_byte;
                  count_in   = count_ff + CW'(1);
                  if (count_ff == CW'(1)) begin
                     b1_in = req_rx_byte;
                  end
                  if (count_ff == CW'(2)) begin
                     b2_in = req_rx_byte;
                  end
               end else begin
                  feed_on_in = 1'b0;
               end
               end_in = req_frame_end;
               if (req_frame_end) begin
                  n_in     = full ? count_ff : count_ff + CW'(1);
                  count_in = '0;
                  func_in  = req_expected_function;
                  nreg_in  = (req_register_count > 5'(MBRC_MAX_REGS)) ?
                             5'(MBRC_MAX_REGS) : req_register_count;
               end
               bit_in   = '0;
               state_in = S_CRC;
            end
         end

         S_CRC: begin
            if (feed_on_ff) begin
               crc_in  = {1'b0, crc_ff[15:1]} ^ (fb ? MBRC_CRC_POLY : 16'h0000);
               feed_in = {1'b0, feed_ff[7:1]};
            end
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               state_in = end_ff ? S_CHECK : S_IDLE;
            end
         end

         S_CHECK: begin
            // The next frame starts with a fresh CRC whatever the outcome.
            crc_in        = MBRC_CRC_INIT;
            rsp_exc_in    = 8'h00;
            rsp_idx_in    = 4'd0;
            rsp_val_in    = 16'h0000;
            rsp_last_in   = 1'b1;
            idx_in        = 4'd0;
            pos_in        = PW'(MBRC_DATA_OFFSET);
            state_in      = S_IDLE;
            if (n_ff < CW'(MBRC_MIN_FRAME)) begin
               rsp_status_in = ST_SHORT;
               rsp_valid_in  = 1'b1;
            end else if (crc_ff != rx_crc) begin
               rsp_status_in = ST_CRC_ERR;
               rsp_valid_in  = 1'b1;
            end else if (b1_ff == ({1'b0, func_ff} | MBRC_EXC_FLAG)) begin
               rsp_status_in = ST_EXCEPTION;
               rsp_exc_in    = b2_ff;
               rsp_valid_in  = 1'b1;
            end else if (b1_ff != {1'b0, func_ff}) begin
               rsp_status_in = ST_FUNC_ERR;
               rsp_valid_in  = 1'b1;
            end else if (nreg_ff == 5'd0) begin
               rsp_status_in = ST_OK;
               rsp_valid_in  = 1'b1;
            end else begin
               rsp_status_in = ST_OK;
               state_in      = S_RD_HI;
            end
         end

         S_RD_HI: begin
            rd_pos   = 32'(pos_ff);
            ram_addr = rd_pos[AW-1:0];
            rd_ok_in = (rd_pos < 32'(MAX_FRAME)) && valid_ff[rd_pos[AW-1:0]];
            state_in = S_RD_LO;
         end

         S_RD_LO: begin
            hi_in    = rd_byte;
            rd_pos   = 32'(pos_ff) + 32'd1;
            ram_addr = rd_pos[AW-1:0];
            rd_ok_in = (rd_pos < 32'(MAX_FRAME)) && valid_ff[rd_pos[AW-1:0]];
            state_in = S_EMIT;
         end

         S_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_exc_in    = 8'h00;
            rsp_idx_in    = idx_ff;
            rsp_val_in    = {hi_ff, rd_byte};
            rsp_last_in   = (({1'b0, idx_ff} + 5'd1) == nreg_ff);
            if (({1'b0, idx_ff} + 5'd1) == nreg_ff) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + 4'd1;
               pos_in   = pos_ff + PW'(2);
               state_in = S_RD_HI;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         crc_ff       <= MBRC_CRC_INIT;
         bit_ff       <= '0;
         feed_on_ff   <= 1'b0;
         end_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         bit_ff       <= bit_in;
         feed_on_ff   <= feed_on_in;
         end_ff       <= end_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feed_ff       <= feed_in;
      h1_ff         <= h1_in;
      h2_ff         <= h2_in;
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      n_ff          <= n_in;
      func_ff       <= func_in;
      nreg_ff       <= nreg_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      hi_ff         <= hi_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_exc_ff    <= rsp_exc_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_fault_code     = rsp_exc_ff;
   assign rsp_register_index = rsp_idx_ff;
   assign rsp_register_value = rsp_val_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Modbus RTU response checker. Frames go in one byte per request.
// A built-in predictor models the frame store and the lagging CRC-16 and checks every result.
// Depends on mbrc_pkg and modbus_rtu_response_checker.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbrc_pkg::*;

   // One request: a received byte plus the fields that are sampled at frame end.
   typedef struct {
      logic [7:0] rx_byte;
      logic       frame_end;
      logic [6:0] func;
      logic [4:0] nreg;
   } req_item_type;

   // One result as the checker reports it.
   typedef struct {
      status_type  status;
      logic [7:0]  exc_code;
      logic [3:0]  reg_index;
      logic [15:0] reg_value;
      logic        last;
   } rsp_item_type;

   typedef logic [7:0] byte_q_type[$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_frame_end = 1'b0;
   logic [6:0]  req_expected_function = 7'h00;
   logic [4:0]  req_register_count = 5'h00;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_fault_code;
   logic [3:0]  rsp_register_index;
   logic [15:0] rsp_register_value;
   logic        rsp_last_result;

   // Requests still to be driven, and results the predictor has promised.
   req_item_type pending_bytes[$];
   rsp_item_type expected_results[$];

   // Shadow copy of the block's state. The store starts out all zero, exactly as
   // after the single reset at the start of the run.
   logic [7:0]  shadow_store [MBRC_MAX_FRAME] = '{default: 8'h00};
   int          shadow_count = 0;
   logic [15:0] shadow_crc = MBRC_CRC_INIT;

   int fail_count = 0;
   bit req_taken = 1'b0;
   int idle_left = 0;
   int sent_count = 0;

   modbus_rtu_response_checker uut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_rx_byte,
      .req_frame_end,
      .req_expected_function,
      .req_register_count,
      .rsp_valid,
      .rsp_status,
      .rsp_fault_code,
      .rsp_register_index,
      .rsp_register_value,
      .rsp_last_result
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // CRC-16/MODBUS, one byte, bit-serial over the reflected polynomial.
   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ MBRC_CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Returns the frame with its CRC appended, low byte first, as a slave sends it.
   function automatic byte_q_type with_crc(byte_q_type frame);
      logic [15:0] c;
      c = MBRC_CRC_INIT;
      foreach (frame[i]) c = crc16_update(c, frame[i]);
      frame.push_back(c[7:0]);
      frame.push_back(c[15:8]);
      return frame;
   endfunction

   // Takes one accepted byte and pushes the results it causes. The running CRC
   // trails the newest stored byte by two, so at frame end it has covered
   // everything but the received CRC. A byte that finds the store full is
   // dropped, and the store is never wiped between frames, so register reads
   // past the end of a short frame see whatever an earlier frame left behind.
   function automatic void predict_frame_results(req_item_type r);
      rsp_item_type res;
      int           n;
      int           regs;
      int           p;
      logic [15:0]  crc_seen;
      logic [7:0]   hi;
      logic [7:0]   lo;
      if (shadow_count < MBRC_MAX_FRAME) begin
         shadow_store[shadow_count] = r.rx_byte;
         shadow_count++;
         if (shadow_count >= 3) begin
            shadow_crc = crc16_update(shadow_crc, shadow_store[shadow_count - 3]);
         end
      end
      if (!r.frame_end) return;

      n = shadow_count;
      crc_seen = shadow_crc;
      shadow_count = 0;
      shadow_crc = MBRC_CRC_INIT;

      res = '{status: ST_OK, exc_code: 8'h00, reg_index: 4'h0, reg_value: 16'h0000,
              last: 1'b1};
      if (n < MBRC_MIN_FRAME) begin
         res.status = ST_SHORT;
      end else if (crc_seen != {shadow_store[n - 1], shadow_store[n - 2]}) begin
         res.status = ST_CRC_ERR;
      end else if (shadow_store[1] == ({1'b0, r.func} | MBRC_EXC_FLAG)) begin
         res.status = ST_EXCEPTION;
         res.exc_code = shadow_store[2];
      end else if (shadow_store[1] != {1'b0, r.func}) begin
         res.status = ST_FUNC_ERR;
      end else begin
         // The register count is clamped to the block's limit and to the
         // sixteen results that one frame can produce.
         regs = (r.nreg > MBRC_MAX_REGS) ? MBRC_MAX_REGS : int'(r.nreg);
         if (regs > 16) regs = 16;
         for (int i = 0; i < regs; i++) begin
            p = MBRC_DATA_OFFSET + 2 * i;
            hi = (p < MBRC_MAX_FRAME) ? shadow_store[p] : 8'h00;
            lo = (p + 1 < MBRC_MAX_FRAME) ? shadow_store[p + 1] : 8'h00;
            res.reg_index = 4'(i);
            res.reg_value = {hi, lo};
            res.last = (i == regs - 1);
            expected_results.push_back(res);
         end
         if (regs != 0) return;
      end
      expected_results.push_back(res);
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Splits a frame into requests. Only the last byte carries frame_end; the
   // function code and register count matter there alone, so the other bytes
   // carry random values in those fields.
   task automatic queue_frame(byte_q_type frame, logic [6:0] func, logic [4:0] nreg);
      req_item_type it;
      foreach (frame[i]) begin
         it.rx_byte = frame[i];
         it.frame_end = (i == frame.size() - 1);
         it.func = it.frame_end ? func : 7'($urandom_range(0, 127));
         it.nreg = it.frame_end ? nreg : 5'($urandom_range(0, 31));
         pending_bytes.push_back(it);
      end
   endtask

   // Builds one frame of the chosen kind. Most kinds are well-formed responses
   // with random content, so the checks get past the CRC; the rest are broken
   // or truncated frames and plain noise.
   task automatic queue_random_frame(int kind);
      byte_q_type frame;
      logic [6:0] func;
      logic [4:0] nreg;
      int         nregs;
      int         k;
      func = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(1, 4));
      nreg = 5'($urandom_range(0, 31));
      frame.push_back(8'($urandom_range(0, 255)));
      if (kind < 40) begin
         // Read response: byte count, then big-endian register data.
         nregs = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
         frame.push_back({1'b0, func});
         frame.push_back(8'(2 * nregs));
         repeat (2 * nregs) frame.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) != 0) nreg = 5'(nregs);
         frame = with_crc(frame);
      end else if (kind < 55) begin
         // Write acknowledgement: address and value or quantity echoed.
         frame.push_back({1'b0, func});
         repeat (4) frame.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 5) != 0) nreg = 5'd0;
         frame = with_crc(frame);
      end else if (kind < 70) begin
         // Exception reply: the function code echoed with its top bit set.
         frame.push_back({1'b1, func});
         frame.push_back(8'($urandom_range(0, 255)));
         frame = with_crc(frame);
      end else if (kind < 80) begin
         // Good CRC, but the function byte matches neither the request nor its
         // exception echo.
         frame.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
         func = frame[1][6:0] ^ 7'($urandom_range(1, 127));
         frame = with_crc(frame);
      end else if (kind < 90) begin
         // One flipped bit anywhere in an otherwise good frame.
         frame.push_back({1'b0, func});
         repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
         frame = with_crc(frame);
         k = $urandom_range(0, frame.size() - 1);
         frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 95) begin
         // Too short to hold even an exception reply.
         repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 98) begin
         repeat ($urandom_range(0, 11)) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
         // A good frame that fills the store exactly, followed by bytes that
         // the block must drop; frame end falls on the last dropped byte.
         frame.push_back({1'b0, func});
         frame.push_back(8'(MBRC_MAX_FRAME - 5));
         repeat (MBRC_MAX_FRAME - 5) frame.push_back(8'($urandom_range(0, 255)));
         frame = with_crc(frame);
         repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
      end
      queue_frame(frame, func, nreg);
   endtask

   // Driver. A request stays on the ports until the block takes it; once it is
   // taken, the next one goes out at this falling edge unless an idle burst is
   // due. Idling comes and goes in stretches of 32 requests and stops
   // altogether for the last 40.
   always @(negedge clock) begin
      req_item_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            start <= 1'b0;
         end else if (pending_bytes.size() > 40 && (sent_count % 64) < 32 &&
                      $urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(0, 5);
            start <= 1'b0;
         end else begin
            nxt = pending_bytes.pop_front();
            req_rx_byte <= nxt.rx_byte;
            req_frame_end <= nxt.frame_end;
            req_expected_function <= nxt.func;
            req_register_count <= nxt.nreg;
            start <= 1'b1;
            sent_count++;
         end
      end
   end

   // Monitor. Results are compared first; a request taken at this same edge
   // cannot have produced one yet, so its prediction is pushed afterwards.
   always @(posedge clock) begin
      rsp_item_type want;
      req_item_type seen;
      req_taken = !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing outstanding: status %0d, value 0x%0h",
                      rsp_status, rsp_register_value);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("fault_code", 16'(want.exc_code), 16'(rsp_fault_code));
               check_field("register_index", 16'(want.reg_index), 16'(rsp_register_index));
               check_field("register_value", want.reg_value, rsp_register_value);
               check_field("last_result", 16'(want.last), 16'(rsp_last_result));
            end
         end
         if (req_taken) begin
            seen.rx_byte = req_rx_byte;
            seen.frame_end = req_frame_end;
            seen.func = req_expected_function;
            seen.nreg = req_register_count;
            predict_frame_results(seen);
         end
      end
   end

   initial begin
      byte_q_type frame;

      // Directed frames. A lone byte at the top of every field range is too
      // short. An exception reply carries its code in the third byte. A write
      // acknowledgement asks for no registers. A read asks for far more
      // registers than it carries, so the count is clamped and the tail is
      // read from stale store contents. Last, a frame whose CRC is off by one bit.
      frame = '{8'hFF};
      queue_frame(frame, 7'h7F, 5'h1F);
      frame = with_crc('{8'h01, 8'h83, 8'h02});
      queue_frame(frame, 7'd3, 5'd0);
      frame = with_crc('{8'h11, 8'h06, 8'h00, 8'h01, 8'h00, 8'h03});
      queue_frame(frame, 7'd6, 5'd0);
      frame = with_crc('{8'h01, 8'h03, 8'h02, 8'hFF, 8'h00});
      queue_frame(frame, 7'd3, 5'h1F);
      frame = with_crc('{8'h02, 8'h04, 8'h00});
      frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h01;
      queue_frame(frame, 7'd4, 5'd1);

      // Random part, led by one frame that overruns the store.
      queue_random_frame(99);
      while (pending_bytes.size() < 270) queue_random_frame($urandom_range(0, 99));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every result to arrive, then
      // leave room for a full sixteen-register burst that should not happen.
      while (pending_bytes.size() != 0 || start || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (80) @(negedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // A correct run takes well under 10 us; anything far beyond that is a hang.
   initial begin
      #200us;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
